// File: sv/sbm_pkg.sv
// Shared types, constants and codes for the smoothed bar level meter.
package sbm_pkg;

   // Bar storage and field widths.
   localparam int BAR_COUNT  = 48;
   localparam int BAR_W      = 6;
   localparam int LEVEL_W    = 15;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 21;
   localparam int PER_BAR_W  = 6;
   localparam int STEP_W     = 14;
   localparam int PHASE_W    = 13;
   localparam int ACC_W      = 30;
   localparam int COEF_W     = 15;
   localparam int DIV_STEPS  = SUM_W;
   localparam int COUNT_W    = 5;

   // Smoothing weights in Q0.15: 0.8 for the old level, 0.2 for the new mean.
   localparam logic [COEF_W-1:0]  KEEP_OLD_Q15 = 15'd26214;
   localparam logic [COEF_W-1:0]  TAKE_NEW_Q15 = 15'd6554;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 15'h7FFF;
   localparam logic [STEP_W-1:0]  STEP_MAX     = 14'd8192;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECIMATION_STEP = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_PER_BAR = 1'd1;
   localparam logic [STEP_W-1:0]      STEP_RESET          = 14'd1;
   localparam logic [PER_BAR_W-1:0]   PER_BAR_RESET       = 6'd11;

   // Input item.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_start;
   } req_payload_type;

   // Result item.
   typedef struct packed {
      logic [BAR_W-1:0]   bar_index;
      logic [LEVEL_W-1:0] bar_level;
      logic               last_bar;
   } rsp_payload_type;

   // Commands from the sequencer to the shared arithmetic unit.
   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_old;
      logic mul_new;
   } arith_ctrl_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_OLD,
      ST_MUL_NEW,
      ST_WRITE
   } state_type;

endpackage

// File: sv/sbm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sbm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sbm_arith.sv
// Shared arithmetic unit: bit-serial divider for the bar mean and the smoothing multiply.
module sbm_arith (
   input  logic                            clock,
   input  sbm_pkg::arith_ctrl_type         ctrl,
   input  logic [sbm_pkg::SUM_W-1:0]       dividend,
   input  logic [sbm_pkg::PER_BAR_W-1:0]   divisor,
   input  logic [sbm_pkg::LEVEL_W-1:0]     old_level,
   output logic [sbm_pkg::LEVEL_W-1:0]     new_level
);
   import sbm_pkg::*;

   logic [PER_BAR_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [PER_BAR_W:0]   trial;
   logic [PER_BAR_W:0]   trial_diff;
   logic [LEVEL_W-1:0]   mean_sat;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      trial      = {rem_ff, quo_ff[SUM_W-1]};
      trial_diff = trial - {1'b0, divisor};
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (ctrl.load) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (ctrl.div_step) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_diff[PER_BAR_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[PER_BAR_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // A mean above full scale can only come from a bar size lowered mid-bar; clamp it.
   always_comb begin
      if (quo_ff > SUM_W'(LEVEL_MAX)) begin
         mean_sat = LEVEL_MAX;
      end else begin
         mean_sat = quo_ff[LEVEL_W-1:0];
      end
   end

   // Weighted sum over two passes through the multiplier.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.mul_old) begin
         acc_in = ACC_W'(KEEP_OLD_Q15 * old_level);
      end else if (ctrl.mul_new) begin
         acc_in = acc_ff + ACC_W'(TAKE_NEW_Q15 * mean_sat);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      acc_ff <= acc_in;
   end

   // The weights sum to one, so the shifted result always fits in Q0.15.
   assign new_level = acc_ff[ACC_W-1:ACC_W-LEVEL_W];

endmodule

// File: sv/smoothed_bar_level_meter.sv
// Top level of the smoothed bar level meter: item accounting, sequencer and level store.
// Sequencing: an item that completes a bar has its result registered after the serial divider
//   (21 divider steps), two multiply passes and the write, which waits while the output is held.
// Input: an item that does not complete a bar leaves the block ready for the next item; after a
//   bar-completing item, input stalls until the 21-step serial divider, both passes and the write are done.
// Reset: synchronous, active high; counters, valid bits and levels read as zero at once.
module smoothed_bar_level_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sbm_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sbm_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_write_en,
   input  logic [sbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sbm_pkg::STEP_W-1:0]        csr_wdata
);
   import sbm_pkg::*;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [PER_BAR_W-1:0]   per_bar_ff, per_bar_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [PER_BAR_W-1:0]   kept_ff, kept_in;
   logic [BAR_W-1:0]       bar_ff, bar_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   done_ff, done_in;
   logic [BAR_W-1:0]       hold_bar_ff, hold_bar_in;
   logic [BAR_COUNT-1:0]   valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic                   accept;
   logic                   out_free;
   logic [STEP_W-1:0]      step_eff;
   logic [PER_BAR_W-1:0]   per_bar_eff;
   logic [PHASE_W-1:0]     phase_base;
   logic [PER_BAR_W-1:0]   kept_base;
   logic [BAR_W-1:0]       bar_base;
   logic [SUM_W-1:0]       sum_base;
   logic                   done_base;
   logic [STEP_W-1:0]      phase_inc;
   logic                   take;
   logic                   complete;
   logic [SAMPLE_W-1:0]    mag_raw;
   logic [LEVEL_W-1:0]     mag;
   logic [SUM_W-1:0]       sum_next;
   logic [PER_BAR_W-1:0]   kept_next;
   logic                   last_base;
   arith_ctrl_type         arith_ctrl;
   logic [LEVEL_W-1:0]     ram_rdata;
   logic [LEVEL_W-1:0]     old_level;
   logic [LEVEL_W-1:0]     new_level;
   logic                   ram_wr_en;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Configuration registers.
   always_comb begin
      step_in    = step_ff;
      per_bar_in = per_bar_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DECIMATION_STEP: step_in    = csr_wdata;
            CSR_SAMPLES_PER_BAR: per_bar_in = csr_wdata[PER_BAR_W-1:0];
            default: begin
               step_in    = step_ff;
               per_bar_in = per_bar_ff;
            end
         endcase
      end
   end

   // Out-of-range settings act as their nearest legal value.
   always_comb begin
      if (step_ff == '0) begin
         step_eff = STEP_W'(1);
      end else if (step_ff > STEP_MAX) begin
         step_eff = STEP_MAX;
      end else begin
         step_eff = step_ff;
      end
      per_bar_eff = (per_bar_ff == '0) ? PER_BAR_W'(1) : per_bar_ff;
   end

   // A frame start clears the frame state before this item is counted.
   always_comb begin
      phase_base = req_payload.frame_start ? '0 : phase_ff;
      kept_base  = req_payload.frame_start ? '0 : kept_ff;
      bar_base   = req_payload.frame_start ? '0 : bar_ff;
      sum_base   = req_payload.frame_start ? '0 : sum_ff;
      done_base  = req_payload.frame_start ? 1'b0 : done_ff;
   end

   // Magnitude of the sample, with the most negative code clamped to full scale.
   always_comb begin
      mag_raw = req_payload.sample[SAMPLE_W-1] ? (~req_payload.sample + SAMPLE_W'(1))
                                               : req_payload.sample;
      mag     = mag_raw[SAMPLE_W-1] ? LEVEL_MAX : mag_raw[LEVEL_W-1:0];
   end

   // Decimation, bar accumulation and bar completion.
   always_comb begin
      phase_inc = {1'b0, phase_base} + STEP_W'(1);
      take      = (phase_base == '0) && !done_base;
      sum_next  = sum_base + SUM_W'(mag);
      kept_next = kept_base + PER_BAR_W'(1);
      complete  = take && (kept_next >= per_bar_eff);
      last_base = (bar_base == BAR_W'(BAR_COUNT - 1));

      phase_in    = phase_ff;
      kept_in     = kept_ff;
      bar_in      = bar_ff;
      sum_in      = sum_ff;
      done_in     = done_ff;
      hold_bar_in = hold_bar_ff;
      if (accept) begin
         phase_in = (phase_inc >= step_eff) ? '0 : phase_inc[PHASE_W-1:0];
         kept_in  = kept_base;
         bar_in   = bar_base;
         sum_in   = sum_base;
         done_in  = done_base;
         if (complete) begin
            kept_in     = '0;
            sum_in      = '0;
            hold_bar_in = bar_base;
            bar_in      = last_base ? '0 : bar_base + BAR_W'(1);
            done_in     = last_base;
         end else if (take) begin
            kept_in = kept_next;
            sum_in  = sum_next;
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (accept && complete) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == COUNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_OLD;
            end
         end
         ST_MUL_OLD: state_in = ST_MUL_NEW;
         ST_MUL_NEW: state_in = ST_WRITE;
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall           = 1'b1;
      arith_ctrl          = '0;
      ram_wr_en           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            arith_ctrl.load = accept && complete;
         end
         ST_DIVIDE:  arith_ctrl.div_step = 1'b1;
         ST_MUL_OLD: arith_ctrl.mul_old  = 1'b1;
         ST_MUL_NEW: arith_ctrl.mul_new  = 1'b1;
         ST_WRITE:   ram_wr_en           = out_free;
         default:    req_stall           = 1'b1;
      endcase
   end

   // Level store: an entry never written since reset reads as zero.
   always_comb begin
      old_level = valid_ff[hold_bar_ff] ? ram_rdata : '0;
      valid_in  = valid_ff;
      if (ram_wr_en) begin
         valid_in[hold_bar_ff] = 1'b1;
      end
   end

   sbm_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (BAR_COUNT)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (hold_bar_ff),
      .wr_data (new_level),
      .rd_en   (accept && complete),
      .rd_addr (bar_base),
      .rd_data (ram_rdata)
   );

   sbm_arith u_arith (
      .clock     (clock),
      .ctrl      (arith_ctrl),
      .dividend  (sum_next),
      .divisor   (per_bar_eff),
      .old_level (old_level),
      .new_level (new_level)
   );

   // Output register: holds a result while the next item is being worked on.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (ram_wr_en) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.bar_index = hold_bar_ff;
         rsp_payload_in.bar_level = new_level;
         rsp_payload_in.last_bar  = (hold_bar_ff == BAR_W'(BAR_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= STEP_RESET;
         per_bar_ff   <= PER_BAR_RESET;
         phase_ff     <= '0;
         kept_ff      <= '0;
         bar_ff       <= '0;
         sum_ff       <= '0;
         done_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         per_bar_ff   <= per_bar_in;
         phase_ff     <= phase_in;
         kept_ff      <= kept_in;
         bar_ff       <= bar_in;
         sum_ff       <= sum_in;
         done_ff      <= done_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_bar_ff    <= hold_bar_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // A bar-completing item always starts the divider.
   assert property (@(posedge clock) disable iff (reset)
      (accept && complete) |=> (state_ff == ST_DIVIDE))
      else $error("completed bar did not start the divider");

   // Leaving the write state always presents a result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && out_free) |=> rsp_valid_ff)
      else $error("bar result was not presented");

   // The last-bar mark goes only with the final bar index.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_bar) |-> (rsp_payload.bar_index == BAR_W'(BAR_COUNT - 1)))
      else $error("last_bar set on a bar other than the final one");

   // No new item is taken while a bar is in the arithmetic unit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_MUL_OLD || state_ff == ST_MUL_NEW) |-> !accept)
      else $error("item accepted while a bar was being computed");
`endif

endmodule
